// File: hw/rtl/qpd_pkg.sv
package qpd_pkg;

   // Characters the decoder looks for or produces
   localparam logic [7:0] CHAR_EQ = 8'h3D;
   localparam logic [7:0] CHAR_US = 8'h5F;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_SP = 8'h20;

   // Most results one item can cause
   localparam int unsigned MAX_RESULTS = 3;

   // Where the decoder stands inside an escape or line break
   typedef enum logic [2:0] {
      PH_NORMAL = 3'd0,
      PH_EQ     = 3'd1,
      PH_HEX1   = 3'd2,
      PH_EQCR   = 3'd3,
      PH_CR     = 3'd4
   } qpd_phase_type;

   // Decoded item handed from the decoder to the result register
   typedef struct packed {
      logic                               load;
      logic [1:0]                         cnt;
      logic [MAX_RESULTS-1:0][7:0]        bytes;
      logic [MAX_RESULTS-1:0]             valids;
      logic                               fin;
   } qpd_load_type;

   // Outcome of one byte decoded as plain text
   typedef struct packed {
      logic [1:0]    cnt;
      logic [7:0]    b0;
      logic [7:0]    b1;
      qpd_phase_type phase;
   } qpd_norm_type;

   // Hex digit value; anything that is not a digit counts as zero
   function automatic logic [3:0] qpd_hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h41 + 8'd10);
      end
      return v;
   endfunction

   // One byte in plain text phase
   function automatic qpd_norm_type qpd_normal_byte(input logic [7:0] b, input logic fin,
                                                    input logic hm);
      qpd_norm_type r;
      r.cnt   = 2'd0;
      r.b0    = 8'h00;
      r.b1    = 8'h00;
      r.phase = PH_NORMAL;
      priority if (b == CHAR_EQ) begin
         if (fin) begin
            r.cnt = 2'd1;
            r.b0  = CHAR_EQ;
         end else begin
            r.phase = PH_EQ;
         end
      end else if (b == CHAR_LF) begin
         r.cnt = 2'd2;
         r.b0  = CHAR_CR;
         r.b1  = CHAR_LF;
      end else if (b == CHAR_CR) begin
         r.phase = PH_CR;
      end else if (b == CHAR_US && hm) begin
         r.cnt = 2'd1;
         r.b0  = CHAR_SP;
      end else begin
         r.cnt = 2'd1;
         r.b0  = b;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/qpd_ifs.sv
// Input channel: one encoded byte per item
interface qpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       final_byte;
   modport source(output valid, output in_byte, output final_byte, input ready);
   modport sink(input valid, input in_byte, input final_byte, output ready);
endinterface

// Result channel: one decoded byte or end marker per item
interface qpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       message_end;
   modport source(output valid, output out_byte, output byte_valid, output run_last,
                  output message_end, input ready);
   modport sink(input valid, input out_byte, input byte_valid, input run_last,
                input message_end, output ready);
endinterface

// Register write channel
interface qpd_csr_if;
   logic valid;
   logic ready;
   logic header_mode;
   modport source(output valid, output header_mode, input ready);
   modport sink(input valid, input header_mode, output ready);
endinterface

// File: hw/rtl/qpd_decode.sv
module qpd_decode import qpd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   qpd_req_if.sink      req_chan,
   input  logic         header_mode,
   input  logic         free,
   output qpd_load_type ld
);

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff;
   logic          in_fin_ff;
   qpd_phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   logic          accept, commit;

   logic [MAX_RESULTS-1:0][7:0] bytes;
   logic [MAX_RESULTS-1:0]      valids;
   logic [1:0]                  cnt;
   qpd_norm_type                nb;

   // Input register moves on when the result register can take its item
   assign commit         = in_valid_ff && free;
   assign req_chan.ready = !in_valid_ff || free;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept ? 1'b1 : (commit ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_byte_ff <= req_chan.in_byte;
         in_fin_ff  <= req_chan.final_byte;
      end
   end

   // Decode the held byte against the escape state
   always_comb begin
      nb       = qpd_normal_byte(in_byte_ff, in_fin_ff, header_mode);
      bytes    = '0;
      valids   = '1;
      cnt      = 2'd0;
      phase_in = PH_NORMAL;
      held_in  = held_ff;
      unique case (phase_ff)
         PH_EQ: begin
            priority if (in_byte_ff == CHAR_LF) begin
               phase_in = PH_NORMAL;
            end else if (in_byte_ff == CHAR_CR) begin
               phase_in = PH_EQCR;
            end else if (in_fin_ff) begin
               // trailing "=X" passes through literally
               bytes[0] = CHAR_EQ;
               bytes[1] = in_byte_ff;
               cnt      = 2'd2;
            end else begin
               held_in  = in_byte_ff;
               phase_in = PH_HEX1;
            end
         end
         PH_HEX1: begin
            bytes[0] = {qpd_hex_value(held_ff), qpd_hex_value(in_byte_ff)};
            cnt      = 2'd1;
            held_in  = 8'h00;
         end
         PH_EQCR: begin
            if (in_byte_ff != CHAR_LF) begin
               bytes[0] = nb.b0;
               bytes[1] = nb.b1;
               cnt      = nb.cnt;
               phase_in = nb.phase;
            end
         end
         PH_CR: begin
            // pending CR becomes CRLF; a following non-LF byte is plain text
            bytes[0] = CHAR_CR;
            bytes[1] = CHAR_LF;
            cnt      = 2'd2;
            if (in_byte_ff != CHAR_LF) begin
               bytes[2] = nb.b0;
               cnt      = 2'(2'd2 + nb.cnt);
               phase_in = nb.phase;
            end
         end
         default: begin
            bytes[0] = nb.b0;
            bytes[1] = nb.b1;
            cnt      = nb.cnt;
            phase_in = nb.phase;
         end
      endcase
      // end of message: bare marker if nothing came out, state back to plain text
      if (in_fin_ff) begin
         if (cnt == 2'd0) begin
            cnt    = 2'd1;
            valids = '0;
         end
         phase_in = PH_NORMAL;
         held_in  = 8'h00;
      end
   end

   assign ld.load   = commit && (cnt != 2'd0);
   assign ld.cnt    = cnt;
   assign ld.bytes  = bytes;
   assign ld.valids = valids;
   assign ld.fin    = in_fin_ff;

   // Escape state advances once per decoded item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL;
         held_ff  <= 8'h00;
      end else if (commit) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   a_fin_resets_phase: assert property (@(posedge clock) disable iff (reset)
      commit && in_fin_ff |=> phase_ff == PH_NORMAL && held_ff == 8'h00)
      else $error("escape state not cleared after last byte");

   a_hex_one_result: assert property (@(posedge clock) disable iff (reset)
      commit && phase_ff == PH_HEX1 |-> ld.load && ld.cnt == 2'd1)
      else $error("hex escape did not give exactly one byte");

endmodule

// File: hw/rtl/qpd_burst.sv
module qpd_burst import qpd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  qpd_load_type ld,
   output logic         free,
   qpd_rsp_if.source    rsp_chan
);

   logic [1:0]                  rem_ff, rem_in;
   logic [MAX_RESULTS-1:0][7:0] byte_ff;
   logic [MAX_RESULTS-1:0]      bv_ff;
   logic                        fin_ff;
   logic                        pop;

   // Room for a new item once the last pending result leaves
   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign free = (rem_ff == 2'd0) || (rem_ff == 2'd1 && rsp_chan.ready);

   always_comb begin
      rem_in = rem_ff;
      if (ld.load) begin
         rem_in = ld.cnt;
      end else if (pop) begin
         rem_in = 2'(rem_ff - 2'd1);
      end
   end

   // Results leave from slot 0; the rest shift down on each take
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
      end
      if (ld.load) begin
         byte_ff <= ld.bytes;
         bv_ff   <= ld.valids;
         fin_ff  <= ld.fin;
      end else if (pop) begin
         byte_ff <= {8'h00, byte_ff[MAX_RESULTS-1:1]};
         bv_ff   <= {1'b0, bv_ff[MAX_RESULTS-1:1]};
      end
   end

   assign rsp_chan.valid       = rem_ff != 2'd0;
   assign rsp_chan.out_byte    = byte_ff[0];
   assign rsp_chan.byte_valid  = bv_ff[0];
   assign rsp_chan.run_last    = rem_ff == 2'd1;
   assign rsp_chan.message_end = (rem_ff == 2'd1) && fin_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ld.load |-> rem_ff == 2'd0 || (rem_ff == 2'd1 && pop))
      else $error("result register overwritten while results pending");

   a_marker_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.byte_valid |-> rsp_chan.run_last && rsp_chan.message_end)
      else $error("end marker not the only result of the last byte");

endmodule

// File: hw/rtl/quoted_printable_decoder.sv
// Quoted-printable decoder.
// req_chan carries one encoded byte per item (in_byte, final_byte marks the
// last byte of a message). rsp_chan carries decoded bytes one per item, with
// run_last on the last result of an input byte and message_end on the final
// result of the message; byte_valid low marks a bare end marker.
// csr_chan writes header_mode (underscore becomes space); it is always
// ready. The user must write it only while the decoder is idle; the
// block itself does not enforce it. An accepted item waits in the input
// register until the result register is free, then is decoded into it.
// Throughput: one input byte per cycle while each byte gives at most one
// result and the receiver is ready. A byte that gives several results holds
// the result register until its last result is taken; input waits behind it.
// The input register keeps taking an item while results wait on a stalled
// receiver; after that the input stalls until the result register drains.
// Reset clears both registers, the escape state and header_mode.
module quoted_printable_decoder import qpd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   qpd_req_if.sink   req_chan,
   qpd_rsp_if.source rsp_chan,
   qpd_csr_if.sink   csr_chan
);

   logic         header_mode_ff;
   logic         free;
   qpd_load_type ld;

   // Configuration register
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_mode_ff <= 1'b0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         header_mode_ff <= csr_chan.header_mode;
      end
   end

   qpd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .header_mode (header_mode_ff),
      .free        (free),
      .ld          (ld)
   );

   qpd_burst u_burst (
      .clock    (clock),
      .reset    (reset),
      .ld       (ld),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

endmodule
